// ===== hdl/mmul_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmul_pkg
// Shared types and constants for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package mmul_pkg;

  // Field widths of the transaction payloads
  localparam int CMD_W   = 2;
  localparam int POS_W   = 3;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 35;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // Default sizes handed to the top level
  localparam int DEFAULT_MAX_DIM    = 8;
  localparam int DEFAULT_ELEM_WIDTH = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [POS_W-1:0]        row_index;
    logic [POS_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic signed [PROD_W-1:0] product_value;
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic                     last;
  } result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/matrix_multiply_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_top
// Fixed-point matrix multiply C = A x B on one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): load an A or B element
//   at a row and column, or start the multiply. Loads are accepted back to
//   back while the block is idle.
//   result channel (result_valid / result_stall / result): after a start,
//   every element of C comes out in row-major order, last set on the final
//   one. Values are exact Q16.16 sums, modulo 2^35.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//   a_rows, inner_dim and b_cols registers; always ready.
// Timing: one shared multiplier and one read port per store. Each result
//   element takes inner_dim reads, a drain of the read / multiply /
//   accumulate pipeline, and a load of the output register; the next
//   element starts only after that load. item_stall stays high until the
//   last element is in the output register.
// Stalls on the result side hold the output register and pause the
//   sequencer before the next element is loaded.
// Reset: dimensions return to 8, the channels go idle; the element stores
//   keep whatever they held and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_multiply_top #(
  parameter int MAX_DIM    = mmul_pkg::DEFAULT_MAX_DIM,
  parameter int ELEM_WIDTH = mmul_pkg::DEFAULT_ELEM_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  mmul_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output mmul_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmul_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmul_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int MUL_W  = 2 * ELEM_WIDTH;
  localparam int EXT_W  = (MUL_W > mmul_pkg::PROD_W) ? MUL_W : mmul_pkg::PROD_W;

  // Configuration registers
  logic [mmul_pkg::CFG_W-1:0] a_rows;
  logic [mmul_pkg::CFG_W-1:0] inner_dim;
  logic [mmul_pkg::CFG_W-1:0] b_cols;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows    <= mmul_pkg::DIM_RESET;
      inner_dim <= mmul_pkg::DIM_RESET;
      b_cols    <= mmul_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmul_pkg::REG_A_ROWS:    a_rows    <= cfg_data;
        mmul_pkg::REG_INNER_DIM: inner_dim <= cfg_data;
        mmul_pkg::REG_B_COLS:    b_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions, clamped to the store size
  logic [DIM_W-1:0] nr, nk, nc;
  assign nr = (32'(a_rows) > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(a_rows);
  assign nk = (32'(inner_dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_dim);
  assign nc = (32'(b_cols) > MAX_DIM)    ? DIM_W'(MAX_DIM) : DIM_W'(b_cols);

  logic dims_ok;
  assign dims_ok = (nr != '0) && (nk != '0) && (nc != '0);

  // Sequencer
  mmul_pkg::state_t state, state_next;
  logic [IDX_W-1:0] r, r_next, c, c_next, k, k_next;
  logic item_accept, issue, out_load;
  logic k_last, r_last, c_last, is_last;

  assign item_stall  = (state != mmul_pkg::ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  assign k_last  = (DIM_W'(k) == nk - DIM_W'(1));
  assign r_last  = (DIM_W'(r) == nr - DIM_W'(1));
  assign c_last  = (DIM_W'(c) == nc - DIM_W'(1));
  assign is_last = r_last && c_last;

  logic rd_v, rd_first, mul_v, mul_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmul_pkg::ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      mmul_pkg::ST_IDLE: begin
        if (item_accept && item.cmd == mmul_pkg::CMD_START && dims_ok) begin
          state_next = mmul_pkg::ST_RUN;
          r_next     = '0;
          c_next     = '0;
          k_next     = '0;
        end
      end
      mmul_pkg::ST_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          k_next     = '0;
          state_next = mmul_pkg::ST_DRAIN;
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      mmul_pkg::ST_DRAIN: begin
        if (!rd_v && !mul_v) begin
          state_next = mmul_pkg::ST_EMIT;
        end
      end
      mmul_pkg::ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          out_load = 1'b1;
          if (is_last) begin
            state_next = mmul_pkg::ST_IDLE;
          end else begin
            state_next = mmul_pkg::ST_RUN;
            if (c_last) begin
              c_next = '0;
              r_next = r + IDX_W'(1);
            end else begin
              c_next = c + IDX_W'(1);
            end
          end
        end
      end
      default: state_next = mmul_pkg::ST_IDLE;
    endcase
  end

  // Element stores: one write port for loads, one registered read port
  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] a_rd, b_rd, wr_val;
  logic [ADDR_W-1:0]     wr_addr, a_addr, b_addr;
  logic                  wr_in_range, wr_a, wr_b;

  assign wr_in_range = (32'(item.row_index) < MAX_DIM) && (32'(item.col_index) < MAX_DIM);
  assign wr_addr = ADDR_W'(ADDR_W'(item.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(item.col_index));
  assign wr_val  = ELEM_WIDTH'($unsigned(item.element_value));
  assign wr_a    = item_accept && wr_in_range && (item.cmd == mmul_pkg::CMD_LOAD_A);
  assign wr_b    = item_accept && wr_in_range && (item.cmd == mmul_pkg::CMD_LOAD_B);

  assign a_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(k));
  assign b_addr = ADDR_W'(ADDR_W'(k) * ADDR_W'(MAX_DIM) + ADDR_W'(c));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= wr_val;
    end
    if (issue) begin
      a_rd <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= wr_val;
    end
    if (issue) begin
      b_rd <= b_mem[b_addr];
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate
  logic signed [MUL_W-1:0]            prod, prod_q;
  logic signed [EXT_W-1:0]            prod_ext;
  logic signed [mmul_pkg::PROD_W-1:0] acc;

  assign prod     = signed'(a_rd) * signed'(b_rd);
  assign prod_ext = EXT_W'(prod_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      rd_first  <= 1'b0;
      mul_v     <= 1'b0;
      mul_first <= 1'b0;
    end else begin
      rd_v      <= issue;
      rd_first  <= issue && (k == '0);
      mul_v     <= rd_v;
      mul_first <= rd_first;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= prod;
    if (mul_v) begin
      if (mul_first) begin
        acc <= prod_ext[mmul_pkg::PROD_W-1:0];
      end else begin
        acc <= acc + prod_ext[mmul_pkg::PROD_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.product_value <= acc;
      result.out_row       <= mmul_pkg::POS_W'(r);
      result.out_col       <= mmul_pkg::POS_W'(c);
      result.last          <= is_last;
    end
  end

  // Checks
  a_mul_follows_read: assert property (@(posedge clk) disable iff (rst)
    mul_v |-> $past(rd_v))
    else $error("multiply stage valid without a read the cycle before");

  a_emit_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mmul_pkg::ST_EMIT) |-> (!rd_v && !mul_v))
    else $error("result emitted while the accumulator is still updating");

  a_read_only_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == mmul_pkg::ST_RUN))
    else $error("store read issued outside the run state");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.cmd == mmul_pkg::CMD_START && dims_ok)
      |=> (state == mmul_pkg::ST_RUN && r == '0 && c == '0 && k == '0))
    else $error("start transaction did not begin at element zero");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && is_last) |=> (state == mmul_pkg::ST_IDLE && result_valid && result.last))
    else $error("final element did not return the sequencer to idle");

endmodule
